// ===== rtl/core/eca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the event clock alignment block.
// No dependencies; imported by eca_pair_ram and event_clock_alignment.
package eca_pkg;

  localparam int ECA_WINDOW_MAX = 32;
  localparam int CLOCK_W        = 32;
  localparam int CFG_W          = 6;
  localparam int OFF_W          = 7;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST       = 6'd16;
  localparam logic [CFG_W-1:0] ALLOWED_DISCREPANCY_RST = 6'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_DISCREPANCY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INIT     = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  // One window entry: trigger side and packet side side by side.
  typedef struct packed {
    logic [CLOCK_W-1:0] trig;
    logic [CLOCK_W-1:0] pkt;
  } clock_pair_t;

endpackage

// ===== rtl/core/event_clock_alignment.sv =====
`timescale 1ns / 1ps
// Event clock alignment top level: sequencer, config registers, window stores.
// Depends on eca_pkg and eca_pair_ram.
//
// Each item carries a trigger clock and a packet clock. Until aligned, the
// clocks and their successive differences fill two circular window stores;
// once the step window reaches window_length entries, the block searches the
// trigger steps for the leading packet steps and, failing that, the packet
// steps for the leading trigger steps, giving a signed event offset and an
// expected trigger-minus-packet difference. After that each item is a match,
// or a mismatch that clears all state. An item without a trigger record
// returns status 3 and touches nothing. Timing: one item is worked at a time.
// An aligned item or one without a trigger goes from S_IDLE to S_FINISH,
// an initialising item through S_PUSH first. The aligning item also runs
// the search over the step store, a read (S_SRD) then a compare (S_SCMP)
// per element, for at most (allowed_discrepancy + 1) * pattern length
// compares, then fetches the clock pair that sets the expected difference
// (S_ERD, S_ECALC). The step read before each compare bounds the search rate.
// No clearing pass is needed: fill counts mark the valid part of each store.
module event_clock_alignment
  import eca_pkg::*;
#(
  parameter int WINDOW_MAX = ECA_WINDOW_MAX
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CLOCK_W-1:0]    trigger_clock,
  input  logic [CLOCK_W-1:0]    pkt_clock,
  input  logic                  trigger_present,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [OFF_W-1:0]      event_offset,
  output logic [CLOCK_W-1:0]    clock_difference,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int IW  = $clog2(WINDOW_MAX);       // store index
  localparam int CW  = $clog2(WINDOW_MAX + 1);   // fill count
  localparam int OW  = CW + 1;                   // signed offset
  localparam int SW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int OXW = (OW > OFF_W) ? OW : OFF_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_SRD, S_SCMP, S_ERD, S_ECALC, S_FINISH
  } state_t;

  // Circular index: base + j wrapped to the store depth.
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] b, input logic [CW-1:0] j);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(j);
    if (s >= (CW+1)'(WINDOW_MAX)) s = s - (CW+1)'(WINDOW_MAX);
    return s[IW-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] off_out(input logic signed [OW-1:0] v);
    logic signed [OXW-1:0] x;
    x = OXW'(v);
    return x[OFF_W-1:0];
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] window_length;
  logic [CFG_W-1:0] allowed_discrepancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length       <= WINDOW_LENGTH_RST;
      allowed_discrepancy <= ALLOWED_DISCREPANCY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:       window_length       <= cfg_data;
        REG_ALLOWED_DISCREPANCY: allowed_discrepancy <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_t                  state;
  logic                    aligned;
  logic signed [OW-1:0]    found_off;
  logic [CLOCK_W-1:0]      expected;
  logic [CW-1:0]           n_c, n_s;
  logic [IW-1:0]           base_c, base_s;
  logic [CLOCK_W-1:0]      last_tc, last_pc;
  logic [CLOCK_W-1:0]      tc_r, pc_r;
  logic [CW-1:0]           plen;
  logic [CW-1:0]           i, k;
  logic                    ok1, ok2, found2;
  logic [CW-1:0]           pos2;
  logic signed [OW-1:0]    off_w;
  status_t                 res_status;
  logic [OFF_W-1:0]        res_off;
  logic [CLOCK_W-1:0]      res_diff;

  clock_pair_t clk_rd_a, clk_rd_b, stp_rd_a, stp_rd_b;
  clock_pair_t clk_wdata, stp_wdata;
  logic        clk_we, stp_we;
  logic [IW-1:0] clk_waddr, clk_ra, clk_rb, stp_waddr, stp_ra, stp_rb;

  // Effective window length, clamped to 1..WINDOW_MAX
  logic [SW-1:0] len_x;
  logic [CW-1:0] len_eff, len_m1;
  always_comb begin
    len_x = SW'(window_length);
    if (window_length == '0) len_eff = CW'(1);
    else if (len_x > SW'(WINDOW_MAX)) len_eff = CW'(WINDOW_MAX);
    else len_eff = len_x[CW-1:0];
    len_m1 = len_eff - CW'(1);
  end

  // Trim to len-1 entries, dropping the oldest
  logic [CW-1:0] nct, nst, n_c_new, n_s_new, plen_new;
  logic [IW-1:0] bct, bst;
  logic [SW-1:0] ad_x, ns_x;
  logic          align_now;
  always_comb begin
    nct = n_c;
    bct = base_c;
    if (n_c >= len_eff) begin
      nct = len_m1;
      bct = wrap(base_c, n_c - len_m1);
    end
    nst = n_s;
    bst = base_s;
    if (n_s >= len_eff) begin
      nst = len_m1;
      bst = wrap(base_s, n_s - len_m1);
    end
    n_c_new   = nct + CW'(1);
    n_s_new   = (nct != '0) ? nst + CW'(1) : nst;
    align_now = (n_s_new >= len_eff);
    ad_x      = SW'(allowed_discrepancy);
    ns_x      = SW'(n_s_new);
    plen_new  = (ad_x < ns_x) ? CW'(ns_x - ad_x) : '0;
  end

  // Search compare: direction one seeks packet steps in trigger steps,
  // direction two the reverse; both run from the same pair of reads.
  logic                 eq1, eq2, o1, o2, last_k, f2n, i_last;
  logic [CW-1:0]        p2n;
  logic signed [OW-1:0] off_fail;
  always_comb begin
    eq1      = (stp_rd_a.trig == stp_rd_b.pkt);
    eq2      = (stp_rd_a.pkt  == stp_rd_b.trig);
    o1       = ok1 & eq1;
    o2       = ok2 & eq2;
    last_k   = (k == plen - CW'(1));
    f2n      = found2 | (last_k & o2);
    p2n      = (last_k & o2 & ~found2) ? i : pos2;
    i_last   = (SW'(i) == ad_x);
    off_fail = f2n ? -(signed'({1'b0, p2n})) : '0;
  end

  // Clock pair index for the expected difference, clamped to the window
  logic [CW-1:0] mag, kk;
  always_comb begin
    mag = off_w[OW-1] ? CW'(-off_w) : CW'(off_w);
    kk  = (mag > n_c - CW'(1)) ? n_c - CW'(1) : mag;
  end

  logic [CLOCK_W-1:0] in_diff, item_diff;
  assign in_diff   = trigger_clock - pkt_clock;
  assign item_diff = tc_r - pc_r;

  // Store port control
  always_comb begin
    clk_we    = (state == S_PUSH);
    clk_waddr = wrap(bct, nct);
    clk_wdata = '{trig: tc_r, pkt: pc_r};
    clk_ra    = wrap(base_c, kk);
    clk_rb    = base_c;
    stp_we    = (state == S_PUSH) && (nct != '0);
    stp_waddr = wrap(bst, nst);
    stp_wdata = '{trig: tc_r - last_tc, pkt: pc_r - last_pc};
    stp_ra    = wrap(base_s, CW'(i + k));
    stp_rb    = wrap(base_s, k);
  end

  eca_pair_ram #(.DEPTH(WINDOW_MAX)) u_clock_ram (
    .clk(clk), .we(clk_we), .waddr(clk_waddr), .wdata(clk_wdata),
    .raddr_a(clk_ra), .raddr_b(clk_rb), .rdata_a(clk_rd_a), .rdata_b(clk_rd_b)
  );

  eca_pair_ram #(.DEPTH(WINDOW_MAX)) u_step_ram (
    .clk(clk), .we(stp_we), .waddr(stp_waddr), .wdata(stp_wdata),
    .raddr_a(stp_ra), .raddr_b(stp_rb), .rdata_a(stp_rd_a), .rdata_b(stp_rd_b)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      aligned   <= 1'b0;
      found_off <= '0;
      expected  <= '0;
      n_c       <= '0;
      n_s       <= '0;
      base_c    <= '0;
      base_s    <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tc_r <= trigger_clock;
            pc_r <= pkt_clock;
            if (!trigger_present) begin
              // No trigger record: report and leave state alone
              res_status <= ST_MISSING;
              res_off    <= '0;
              res_diff   <= '0;
              state      <= S_FINISH;
            end else if (aligned) begin
              res_off  <= off_out(found_off);
              res_diff <= in_diff;
              state    <= S_FINISH;
              if (in_diff == expected) begin
                res_status <= ST_MATCH;
              end else begin
                // Mismatch: drop every window and the alignment
                res_status <= ST_MISMATCH;
                aligned    <= 1'b0;
                found_off  <= '0;
                expected   <= '0;
                n_c        <= '0;
                n_s        <= '0;
                base_c     <= '0;
                base_s     <= '0;
              end
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          n_c     <= n_c_new;
          n_s     <= n_s_new;
          base_c  <= bct;
          base_s  <= bst;
          last_tc <= tc_r;
          last_pc <= pc_r;
          if (align_now) begin
            plen <= plen_new;
            if (plen_new == '0) begin
              off_w <= '0;
              state <= S_ERD;
            end else begin
              i      <= '0;
              k      <= '0;
              ok1    <= 1'b1;
              ok2    <= 1'b1;
              found2 <= 1'b0;
              state  <= S_SRD;
            end
          end else begin
            res_status <= ST_INIT;
            res_off    <= off_out(found_off);
            res_diff   <= item_diff;
            state      <= S_FINISH;
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (last_k && o1) begin
            off_w <= signed'({1'b0, i});
            state <= S_ERD;
          end else begin
            found2 <= f2n;
            pos2   <= p2n;
            if ((!o1 && !o2) || last_k) begin
              if (i_last) begin
                off_w <= off_fail;
                state <= S_ERD;
              end else begin
                i     <= i + CW'(1);
                k     <= '0;
                ok1   <= 1'b1;
                ok2   <= ~f2n;
                state <= S_SRD;
              end
            end else begin
              k     <= k + CW'(1);
              ok1   <= o1;
              ok2   <= o2;
              state <= S_SRD;
            end
          end
        end
        S_ERD: begin
          state <= S_ECALC;
        end
        S_ECALC: begin
          // Positive offset: trigger clock k against oldest packet clock;
          // negative: oldest trigger clock against packet clock k.
          expected   <= off_w[OW-1] ? (clk_rd_b.trig - clk_rd_a.pkt)
                                    : (clk_rd_a.trig - clk_rd_b.pkt);
          aligned    <= 1'b1;
          found_off  <= off_w;
          res_status <= ST_INIT;
          res_off    <= off_out(off_w);
          res_diff   <= item_diff;
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            status           <= res_status;
            event_offset     <= res_off;
            clock_difference <= res_diff;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_search_when_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCMP) |-> !aligned)
    else $error("pattern search running while aligned");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    n_s <= n_c)
    else $error("step window longer than clock window");

  a_missing_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !trigger_present) |=>
      (state == S_FINISH) && (res_status == ST_MISSING))
    else $error("missing trigger item not reported directly");

  a_k_in_pattern: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCMP) |-> (k < plen))
    else $error("pattern index beyond pattern length");

  a_finish_hands_over: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && (!out_valid || out_ready)) |=>
      out_valid && (state == S_IDLE))
    else $error("result not loaded into output register");

endmodule

// ===== rtl/core/eca_pair_ram.sv =====
`timescale 1ns / 1ps
// Window store: one write port, two registered read ports, clock_pair_t entries.
// Depends on eca_pkg.
module eca_pair_ram
  import eca_pkg::*;
#(
  parameter int DEPTH = ECA_WINDOW_MAX
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  clock_pair_t              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output clock_pair_t              rdata_a,
  output clock_pair_t              rdata_b
);

  clock_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
